// ----- hdl/kst_pkg.sv -----
package kst_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 8;

	localparam logic [1:0] REQ_SEARCH = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} slot_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic rd;
		logic commit;
	} kst_cmd_t;

	typedef struct packed {
		logic cnt_last;
	} kst_stat_t;

endpackage

// ----- hdl/kst_ctrl.sv -----
module kst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output kst_pkg::kst_cmd_t  cmd,
	input  kst_pkg::kst_stat_t stat
);
	import kst_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.cnt_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.cnt_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.clr_wr = (state_q == S_CLEAR);
	assign cmd.rd     = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transfer");
`endif

endmodule

// ----- hdl/kst_dp.sv -----
module kst_dp #(
	parameter int ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kst_pkg::kst_cmd_t         cmd,
	output kst_pkg::kst_stat_t        stat,
	input  logic [1:0]                req_type,
	input  logic [kst_pkg::KEY_W-1:0] key,
	input  logic [kst_pkg::VAL_W-1:0] entry_value,
	output logic                      done,
	output logic [1:0]                status,
	output logic [kst_pkg::VAL_W-1:0] found_value
);
	import kst_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	slot_t            mem [ENTRIES];
	slot_t            rdata_q;
	logic [AW-1:0]    cnt_q;
	logic [AW-1:0]    addr_s1;
	logic             rd_s1;

	logic [1:0]       req_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic             hit_q;
	logic             free_q;
	logic [AW-1:0]    hit_idx_q;
	logic [AW-1:0]    free_idx_q;
	logic [VAL_W-1:0] hit_val_q;

	logic             done_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] found_q;

	logic             cnt_last;
	logic             we;
	logic [AW-1:0]    wa;
	slot_t            wd;

	assign cnt_last      = (cnt_q == AW'(ENTRIES - 1));
	assign stat.cnt_last = cnt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.clr_wr || cmd.rd) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	// write port: clearing pass or commit of the current request
	always_comb begin
		we = 1'b0;
		wa = cnt_q;
		wd = '0;
		if (cmd.clr_wr) begin
			we = 1'b1;
		end else if (cmd.commit) begin
			case (req_q)
				REQ_INSERT: begin
					we = !hit_q && free_q;
					wa = free_idx_q;
					wd = '{valid: 1'b1, key: key_q, val: val_q};
				end
				REQ_DELETE: begin
					we = hit_q;
					wa = hit_idx_q;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd) begin
			rdata_q <= mem[cnt_q];
			addr_s1 <= cnt_q;
		end
	end

	// request latch and scan bookkeeping; first match and lowest free slot win
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_s1) begin
			if (rdata_q.valid && (rdata_q.key == key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!rdata_q.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= key;
			val_q <= entry_value;
		end
		if (rd_s1 && !cmd.load) begin
			if (rdata_q.valid && (rdata_q.key == key_q) && !hit_q) begin
				hit_idx_q <= addr_s1;
				hit_val_q <= rdata_q.val;
			end
			if (!rdata_q.valid && !free_q) begin
				free_idx_q <= addr_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= ST_MISS;
			found_q  <= '0;
			case (req_q)
				REQ_SEARCH: begin
					if (hit_q) begin
						status_q <= ST_OK;
						found_q  <= hit_val_q;
					end
				end
				REQ_INSERT: begin
					if (!hit_q) begin
						status_q <= free_q ? ST_OK : ST_FULL;
					end
				end
				REQ_DELETE: begin
					if (hit_q) begin
						status_q <= ST_OK;
					end
				end
				default: begin
					status_q <= ST_MISS;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;

`ifndef SYNTHESIS
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit))
		else $error("result strobe without commit");
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_s1)
		else $error("commit before last slot was evaluated");
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && (cmd.clr_wr || cmd.commit)))
		else $error("slot read and write in the same cycle");
	a_value_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (found_value != '0) |-> (status == ST_OK))
		else $error("nonzero value without a hit");
`endif

endmodule

// ----- hdl/keyed_set_table_core.sv -----
// Key/value table of ENTRIES slots with unique 32-bit keys. A request
// (search, insert, delete) transfers when start is high and busy is low;
// it scans every slot through the single memory read port, one slot per
// cycle, then commits; the next request can transfer only after the
// commit. The result appears on status/found_value in the cycle after
// the commit, marked by done for exactly one cycle; the receiver cannot
// stall it, so it must take it then. A new request may transfer in that
// same cycle. After reset the block clears the valid flag of every slot,
// one per cycle, and holds busy high until the clearing pass is done.
module keyed_set_table_core #(
	parameter int ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic signed [31:0]        key,
	input  logic [7:0]                entry_value,
	output logic                      done,
	output logic [1:0]                status,
	output logic [7:0]                found_value
);
	import kst_pkg::*;

	kst_cmd_t  cmd;
	kst_stat_t stat;

	kst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	kst_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.key         (key),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.found_value (found_value)
	);

endmodule

// ----- verif/keyed_set_table_core_tb.sv -----
`timescale 1ns / 100ps

module keyed_set_table_core_tb;
	import kst_pkg::*;

	localparam int ENTRIES = 16;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_ITEMS = 1050;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  req;
		logic [31:0] key;
		logic [7:0]  val;
		int unsigned gap;
		bit          drain;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [7:0] value;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         req_type = REQ_SEARCH;
	logic signed [31:0] key = '0;
	logic [7:0]         entry_value = '0;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         found_value;

	request_t    request_q[$];
	reply_t      pending_replies[$];
	logic [31:0] key_pool[POOL_SIZE];

	// shadow copy of the table contents
	logic [31:0] shadow_key[ENTRIES];
	logic [7:0]  shadow_val[ENTRIES];
	bit          shadow_used[ENTRIES];

	int errors = 0;
	int accepted = 0;
	int total_items;
	bit took = 1'b0;

	keyed_set_table_core #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.entry_value(entry_value),
		.done(done),
		.status(status),
		.found_value(found_value)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic reply_t apply_to_shadow(input logic [1:0] req, input logic [31:0] k,
			input logic [7:0] v);
		reply_t r;
		int hit;
		int free_idx;
		hit = -1;
		free_idx = -1;
		r.status = ST_MISS;
		r.value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && shadow_used[i] && shadow_key[i] == k)
				hit = i;
			if (free_idx < 0 && !shadow_used[i])
				free_idx = i;
		end
		case (req)
			REQ_SEARCH: begin
				if (hit >= 0) begin
					r.status = ST_OK;
					r.value = shadow_val[hit];
				end
			end
			REQ_INSERT: begin
				if (hit < 0) begin
					if (free_idx < 0) begin
						r.status = ST_FULL;
					end else begin
						shadow_key[free_idx] = k;
						shadow_val[free_idx] = v;
						shadow_used[free_idx] = 1'b1;
						r.status = ST_OK;
					end
				end
			end
			REQ_DELETE: begin
				if (hit >= 0) begin
					shadow_used[hit] = 1'b0;
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_request(input logic [1:0] req, input logic [31:0] k,
			input logic [7:0] v, input int unsigned gap, input bit drain);
		request_t it;
		it.req = req;
		it.key = k;
		it.val = v;
		it.gap = gap;
		it.drain = drain;
		request_q.push_back(it);
	endfunction

	// driver: inputs change on the falling edge
	request_t    cur;
	bit          armed = 1'b0;
	int unsigned wait_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// transfer still pending, hold the request
		end else begin
			if (!armed && request_q.size() != 0) begin
				cur = request_q.pop_front();
				wait_left = cur.gap;
				armed = 1'b1;
			end
			if (!armed) begin
				start <= 1'b0;
			end else if (cur.drain && pending_replies.size() != 0) begin
				start <= 1'b0;
			end else if (wait_left != 0) begin
				wait_left--;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req_type <= cur.req;
				key <= cur.key;
				entry_value <= cur.val;
				armed = 1'b0;
			end
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk or negedge arst_n) begin
		reply_t exp_r;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (done) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected result status %0d found_value %0d",
						$time, status, found_value);
					errors++;
				end else begin
					exp_r = pending_replies.pop_front();
					if (status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.status, status);
						errors++;
					end
					if (found_value !== exp_r.value) begin
						$display("%0t: found_value expected %0d actual %0d",
							$time, exp_r.value, found_value);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				pending_replies.push_back(apply_to_shadow(req_type, key, entry_value));
				accepted++;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("[keyed_set_table_core] ERROR");
		$finish;
	end

	initial begin
		int mode;
		int idle_style;
		int len;
		int pick;
		logic [1:0] rq;
		logic [31:0] k;
		int unsigned gap;

		for (int i = 0; i < ENTRIES; i++)
			shadow_used[i] = 1'b0;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		key_pool[4] = 32'h0000_0001;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// empty table, unused code
		add_request(REQ_SEARCH, key_pool[2], 8'hFF, 0, 1'b0);
		add_request(REQ_DELETE, key_pool[3], 8'h00, 0, 1'b0);
		add_request(REQ_UNUSED, key_pool[0], 8'hFF, $urandom_range(0, 17), 1'b0);
		// fill every slot, extremes of key and value first
		add_request(REQ_INSERT, key_pool[0], 8'hFF, 0, 1'b0);
		add_request(REQ_INSERT, key_pool[1], 8'h00, 0, 1'b0);
		add_request(REQ_INSERT, key_pool[2], 8'h55, 0, 1'b0);
		add_request(REQ_INSERT, key_pool[3], 8'hAA, 0, 1'b0);
		for (int i = 4; i < ENTRIES; i++)
			add_request(REQ_INSERT, key_pool[i], 8'($urandom_range(0, 255)),
				$urandom_range(0, 17), 1'b0);
		// full table: new key, then a key already present
		add_request(REQ_INSERT, key_pool[ENTRIES], 8'h12, 0, 1'b0);
		add_request(REQ_INSERT, key_pool[1], 8'h34, 0, 1'b0);
		add_request(REQ_SEARCH, key_pool[0], 8'h00, $urandom_range(0, 17), 1'b0);
		add_request(REQ_SEARCH, key_pool[ENTRIES + 1], 8'h00, 0, 1'b0);
		add_request(REQ_DELETE, key_pool[3], 8'hFF, 0, 1'b0);
		add_request(REQ_DELETE, key_pool[3], 8'hFF, 0, 1'b0);

		// random bursts: fill, empty, mixed and lookup-heavy phases
		while (request_q.size() < 25 + RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			idle_style = $urandom_range(0, 2);
			len = $urandom_range(8, 40);
			for (int j = 0; j < len; j++) begin
				pick = $urandom_range(0, 99);
				case (mode)
					0: rq = pick < 75 ? REQ_INSERT : pick < 90 ? REQ_SEARCH :
						pick < 98 ? REQ_DELETE : REQ_UNUSED;
					1: rq = pick < 60 ? REQ_DELETE : pick < 85 ? REQ_SEARCH :
						pick < 98 ? REQ_INSERT : REQ_UNUSED;
					2: rq = pick < 35 ? REQ_INSERT : pick < 70 ? REQ_SEARCH :
						pick < 98 ? REQ_DELETE : REQ_UNUSED;
					default: rq = pick < 70 ? REQ_SEARCH : pick < 85 ? REQ_INSERT :
						pick < 98 ? REQ_DELETE : REQ_UNUSED;
				endcase
				k = $urandom_range(0, 99) < 88 ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom;
				case (idle_style)
					0: gap = 0;
					1: gap = $urandom_range(0, 17);
					default: gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 17) : 0;
				endcase
				// first random item always waits for the block to drain
				add_request(rq, k, 8'($urandom_range(0, 255)), gap,
					(j == 0) && (request_q.size() == 25 || $urandom_range(0, 5) == 0));
			end
		end
		total_items = request_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted != total_items)
			@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("[keyed_set_table_core] OK");
		else
			$display("[keyed_set_table_core] ERROR");
		$finish;
	end

endmodule
